/* rtl/disparity_colormap_pixel_assert.svh */
// Assertion macros for the disparity colormap RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef DISPARITY_COLORMAP_PIXEL_ASSERT_SVH
`define DISPARITY_COLORMAP_PIXEL_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DCP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("dcp assertion failed");
`define DCP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("dcp assertion failed");
`else
`define DCP_ASSERT(lbl, clk, rst_n, prop)
`define DCP_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* rtl/dcp_pkg.sv */
// Package for the disparity colormap block: item types, codes, control structs
// and the quarter-segment colormap tables. No dependencies.
package dcp_pkg;

    localparam int DISP_BITS      = 16;
    localparam int FRACTION_DEF   = 16;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [1:0] ACT_START  = 2'd0;
    localparam logic [1:0] ACT_SCAN   = 2'd1;
    localparam logic [1:0] ACT_COLOR  = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic [1:0] MAP_JET     = 2'd0;
    localparam logic [1:0] MAP_INFERNO = 2'd1;
    localparam logic [1:0] MAP_VIRIDIS = 2'd2;
    localparam logic [1:0] MAP_GRAY    = 2'd3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_AUTO_RANGE = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COLORMAP   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RANGE_LOW  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RANGE_HIGH = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNIT       = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INV_RED    = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INV_GREEN  = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INV_BLUE   = 3'd7;

    typedef struct packed {
        logic [1:0]           action;
        logic [DISP_BITS-1:0] disparity;
        logic                 not_finite;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_out_item;

    typedef struct packed {
        logic clear_seen;
        logic scan;
        logic load_pixel;
        logic setup;
        logic start_div;
        logic div_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic pix_ok;
        logic skip_div;
    } t_status;

    // base value of segment s, channel c (0 red, 1 green, 2 blue)
    function automatic logic signed [9:0] seg_base(logic viridis, logic [1:0] s,
                                                   logic [1:0] c);
        logic signed [9:0] r;
        r = '0;
        if (!viridis) begin
            case ({s, c})
                4'b00_00: r = 10'sd0;   4'b00_01: r = 10'sd0;   4'b00_10: r = 10'sd0;
                4'b01_00: r = 10'sd80;  4'b01_01: r = 10'sd18;  4'b01_10: r = 10'sd120;
                4'b10_00: r = 10'sd200; 4'b10_01: r = 10'sd50;  4'b10_10: r = 10'sd140;
                4'b11_00: r = 10'sd252; 4'b11_01: r = 10'sd150; 4'b11_10: r = 10'sd40;
                default:  r = '0;
            endcase
        end else begin
            case ({s, c})
                4'b00_00: r = 10'sd68;  4'b00_01: r = 10'sd1;   4'b00_10: r = 10'sd84;
                4'b01_00: r = 10'sd59;  4'b01_01: r = 10'sd82;  4'b01_10: r = 10'sd139;
                4'b10_00: r = 10'sd33;  4'b10_01: r = 10'sd145; 4'b10_10: r = 10'sd140;
                4'b11_00: r = 10'sd94;  4'b11_01: r = 10'sd201; 4'b11_10: r = 10'sd98;
                default:  r = '0;
            endcase
        end
        return r;
    endfunction

    function automatic logic signed [9:0] seg_delta(logic viridis, logic [1:0] s,
                                                    logic [1:0] c);
        logic signed [9:0] r;
        r = '0;
        if (!viridis) begin
            case ({s, c})
                4'b00_00: r = 10'sd80;  4'b00_01: r = 10'sd18;  4'b00_10: r = 10'sd120;
                4'b01_00: r = 10'sd120; 4'b01_01: r = 10'sd32;  4'b01_10: r = 10'sd20;
                4'b10_00: r = 10'sd52;  4'b10_01: r = 10'sd100; 4'b10_10: r = -10'sd100;
                4'b11_00: r = 10'sd3;   4'b11_01: r = 10'sd105; 4'b11_10: r = 10'sd100;
                default:  r = '0;
            endcase
        end else begin
            case ({s, c})
                4'b00_00: r = -10'sd9;  4'b00_01: r = 10'sd81;  4'b00_10: r = 10'sd55;
                4'b01_00: r = -10'sd26; 4'b01_01: r = 10'sd63;  4'b01_10: r = 10'sd1;
                4'b10_00: r = 10'sd61;  4'b10_01: r = 10'sd56;  4'b10_10: r = -10'sd42;
                4'b11_00: r = 10'sd159; 4'b11_01: r = 10'sd30;  4'b11_10: r = -10'sd61;
                default:  r = '0;
            endcase
        end
        return r;
    endfunction

endpackage

/* rtl/disparity_colormap_pixel.sv */
// Disparity to RGB false-color converter, top level.
// Depends on dcp_pkg, dcp_ctrl and dcp_datapath.
//
// Input channel: i_in_valid / o_in_stall carry one item (action, disparity,
// not_finite). Start-frame clears the scanned range, scan folds a valid
// pixel into it, color produces one RGB item on the output channel.
// Output channel: o_out_valid / i_out_stall with an output register.
// Start and scan items are handled in the idle state and can follow back to back.
// A color item steps through setup, start, the divide steps and the map state
// before its result is loaded into the output register, and the next item is
// accepted once the controller is back in idle; the bit-serial restoring
// divider retires one quotient bit per cycle. Invalid pixels go from setup
// straight to the map state; pixels at or outside the range skip the divide
// steps (setup, start, map). One item is in work at a time; the next is
// accepted while a finished result still waits in the output register.
// When the receiver stalls, the result holds and a following color item
// waits at its last step until the register frees.
// Reset (synchronous, active low) loads the register defaults and clears the
// scanned range. Config writes are always ready and must come while idle.
module disparity_colormap_pixel #(
    parameter int FRACTION_BITS = dcp_pkg::FRACTION_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  dcp_pkg::t_in_item                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output dcp_pkg::t_out_item                o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [dcp_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [dcp_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import dcp_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    dcp_ctrl #(.FRACTION_BITS(FRACTION_BITS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_action    (i_in_data.action),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    dcp_datapath #(.FRACTION_BITS(FRACTION_BITS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_data  (o_out_data)
    );
endmodule

/* rtl/dcp_ctrl.sv */
// Controller for the disparity colormap block: item sequencing and divider steps.
// Depends on dcp_pkg and the assertion macro header.
`include "disparity_colormap_pixel_assert.svh"
module dcp_ctrl #(
    parameter int FRACTION_BITS = dcp_pkg::FRACTION_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_action,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  dcp_pkg::t_status  i_status,
    output dcp_pkg::t_cmd     o_cmd
);
    import dcp_pkg::*;

    localparam int CNT_BITS = $clog2(FRACTION_BITS);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SETUP = 5'b00010,
        S_START = 5'b00100,
        S_DIV   = 5'b01000,
        S_MAP   = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic                r_out_valid, n_out_valid;
    logic                accept;
    t_cmd                cmd;

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_action)
                        ACT_START: cmd.clear_seen = 1'b1;
                        ACT_SCAN:  cmd.scan = 1'b1;
                        ACT_COLOR: begin
                            cmd.load_pixel = 1'b1;
                            n_state = S_SETUP;
                        end
                        default: ;
                    endcase
                end
            end
            S_SETUP: begin
                cmd.setup = 1'b1;
                n_state = i_status.pix_ok ? S_START : S_MAP;
            end
            S_START: begin
                cmd.start_div = 1'b1;
                n_cnt = '0;
                n_state = i_status.skip_div ? S_MAP : S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(FRACTION_BITS - 1)) begin
                    n_state = S_MAP;
                end
            end
            S_MAP: begin
                if (!r_out_valid || !i_out_stall) begin
                    cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign n_out_valid = cmd.load_out || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    `DCP_ASSERT(a_div_ends, i_clk, i_rst_n,
        (r_state == S_DIV && r_cnt == CNT_BITS'(FRACTION_BITS - 1)) |=> (r_state == S_MAP))
    `DCP_ASSERT(a_no_overwrite, i_clk, i_rst_n,
        cmd.load_out |-> (!r_out_valid || !i_out_stall))
    `DCP_ASSERT(a_cnt_range, i_clk, i_rst_n,
        (r_state == S_DIV) |-> (r_cnt <= CNT_BITS'(FRACTION_BITS - 1)))
endmodule

/* rtl/dcp_datapath.sv */
// Datapath for the disparity colormap block: config registers, scan range,
// bit-serial normalizing divider and colormap evaluation. Depends on dcp_pkg.
module dcp_datapath #(
    parameter int FRACTION_BITS = dcp_pkg::FRACTION_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [dcp_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [dcp_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    input  dcp_pkg::t_in_item                     i_in_data,
    input  dcp_pkg::t_cmd                         i_cmd,
    output dcp_pkg::t_status                      o_status,
    output dcp_pkg::t_out_item                    o_out_data
);
    import dcp_pkg::*;

    localparam int F  = FRACTION_BITS;
    localparam int CW = F + 11;
    localparam int DB = DISP_BITS;
    localparam logic signed [CW-1:0] ONE  = CW'(1) <<< F;
    localparam logic signed [CW-1:0] E1   = ONE >>> 3;
    localparam logic signed [CW-1:0] E3   = E1 * 3;
    localparam logic signed [CW-1:0] E5   = E1 * 5;
    localparam logic signed [CW-1:0] E7   = E1 * 7;
    localparam logic signed [CW-1:0] FULL = ONE * 255;

    logic          r_auto;
    logic [1:0]    r_cmap;
    logic [DB-1:0] r_rlo, r_rhi, r_unit;
    logic [7:0]    r_inv_r, r_inv_g, r_inv_b;
    logic [DB-1:0] r_min, r_max;
    logic          r_seen;
    logic [DB-1:0] r_disp, r_lo, r_span, r_rem;
    logic          r_pix_ok;
    logic [F:0]    r_n;
    t_out_item     r_out;

    logic          in_ok;
    logic [DB-1:0] unit, lo, hi, diff;
    logic [DB:0]   span_raw, rem2;
    logic          le_lo, ge_span;

    t_out_item            map_rgb;
    logic signed [CW-1:0] nx, tq, acc [3];
    logic [2:0]           sfull;
    logic [1:0]           seg;

    assign in_ok = (i_in_data.disparity != '0) && !i_in_data.not_finite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto  <= 1'b0;
            r_cmap  <= MAP_JET;
            r_rlo   <= '0;
            r_rhi   <= '1;
            r_unit  <= DB'(1);
            r_inv_r <= '0;
            r_inv_g <= '0;
            r_inv_b <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_AUTO_RANGE: r_auto  <= i_cfg_data[0];
                CFG_COLORMAP:   r_cmap  <= i_cfg_data[1:0];
                CFG_RANGE_LOW:  r_rlo   <= i_cfg_data;
                CFG_RANGE_HIGH: r_rhi   <= i_cfg_data;
                CFG_UNIT:       r_unit  <= i_cfg_data;
                CFG_INV_RED:    r_inv_r <= i_cfg_data[7:0];
                CFG_INV_GREEN:  r_inv_g <= i_cfg_data[7:0];
                CFG_INV_BLUE:   r_inv_b <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min  <= '1;
            r_max  <= '0;
            r_seen <= 1'b0;
        end else if (i_cmd.clear_seen) begin
            r_min  <= '1;
            r_max  <= '0;
            r_seen <= 1'b0;
        end else if (i_cmd.scan && in_ok) begin
            if (i_in_data.disparity < r_min) r_min <= i_in_data.disparity;
            if (i_in_data.disparity > r_max) r_max <= i_in_data.disparity;
            r_seen <= 1'b1;
        end
    end

    // range selection
    always_comb begin
        unit = (r_unit == '0) ? DB'(1) : r_unit;
        if (r_auto) begin
            lo = r_seen ? r_min : '0;
            hi = r_seen ? r_max : unit;
        end else begin
            lo = r_rlo;
            hi = r_rhi;
        end
        span_raw = {1'b0, hi} - {1'b0, lo};
    end

    assign diff    = r_disp - r_lo;
    assign le_lo   = (r_disp <= r_lo);
    assign ge_span = (diff >= r_span);
    assign rem2    = {r_rem, 1'b0};

    assign o_status.pix_ok   = r_pix_ok;
    assign o_status.skip_div = le_lo || ge_span;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pixel) begin
            r_disp   <= i_in_data.disparity;
            r_pix_ok <= in_ok;
        end
        if (i_cmd.setup) begin
            r_lo   <= lo;
            r_span <= (span_raw[DB] || span_raw == '0) ? unit : span_raw[DB-1:0];
        end
        if (i_cmd.start_div) begin
            r_rem <= diff;
            if (le_lo) r_n <= '0;
            else if (ge_span) r_n <= {1'b1, {F{1'b0}}};
            else r_n <= '0;
        end
        if (i_cmd.div_step) begin
            if (rem2 >= {1'b0, r_span}) begin
                r_rem <= DB'(rem2 - {1'b0, r_span});
                r_n   <= {r_n[F-1:0], 1'b1};
            end else begin
                r_rem <= rem2[DB-1:0];
                r_n   <= {r_n[F-1:0], 1'b0};
            end
        end
        if (i_cmd.load_out) begin
            r_out <= r_pix_ok ? map_rgb
                              : t_out_item'{red: r_inv_r, green: r_inv_g, blue: r_inv_b};
        end
    end

    // colormap evaluation from the normalized value
    function automatic logic [7:0] fix_floor(logic signed [CW-1:0] x);
        logic signed [CW-1:0] v;
        v = x >>> F;
        if (x < 0) return 8'd0;
        if (v > CW'(255)) return 8'd255;
        return v[7:0];
    endfunction

    always_comb begin
        nx    = signed'(CW'(r_n));
        sfull = r_n[F:F-2];
        seg   = (sfull > 3'd3) ? 2'd3 : sfull[1:0];
        tq    = (nx <<< 2) - (signed'(CW'(seg)) <<< F);
        for (int c = 0; c < 3; c++) begin
            acc[c] = (CW'(seg_base(r_cmap == MAP_VIRIDIS, seg, 2'(c))) <<< F)
                   + tq * CW'(seg_delta(r_cmap == MAP_VIRIDIS, seg, 2'(c)));
        end
        map_rgb = '0;
        case (r_cmap)
            MAP_JET: begin
                if (nx < E1) begin
                    map_rgb.blue = fix_floor((ONE <<< 7) + nx * CW'(1016));
                end else if (nx < E3) begin
                    map_rgb.green = fix_floor((nx - E1) * CW'(1020));
                    map_rgb.blue  = 8'd255;
                end else if (nx < E5) begin
                    map_rgb.red   = fix_floor((nx - E3) * CW'(1020));
                    map_rgb.green = 8'd255;
                    map_rgb.blue  = fix_floor(FULL - (nx - E3) * CW'(1020));
                end else if (nx < E7) begin
                    map_rgb.red   = 8'd255;
                    map_rgb.green = fix_floor(FULL - (nx - E5) * CW'(1020));
                end else begin
                    map_rgb.red   = fix_floor(FULL - (nx - E7) * CW'(1016));
                end
            end
            MAP_INFERNO, MAP_VIRIDIS: begin
                map_rgb.red   = fix_floor(acc[0]);
                map_rgb.green = fix_floor(acc[1]);
                map_rgb.blue  = fix_floor(acc[2]);
            end
            default: begin
                map_rgb.red   = fix_floor(nx * CW'(255));
                map_rgb.green = map_rgb.red;
                map_rgb.blue  = map_rgb.red;
            end
        endcase
    end

    assign o_out_data = r_out;
endmodule
